@@ design/psx_pkg.sv @@
// shared types, constants and helpers of the printable string extractor
package psx_pkg;

   // shortest run that is reported as a string
   localparam int MIN_RUN = 4;
   localparam int HELD_DEPTH = MIN_RUN - 1;
   localparam int COUNT_W = $clog2(MIN_RUN + 1);
   localparam int SLOT_W = $clog2(MIN_RUN + 1);

   localparam int ADDR_W = 48;
   localparam int OFFSET_W = 32;
   localparam int CSR_DATA_W = 48;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // ascii codes used by the classifier
   localparam logic [7:0] CHAR_TAB = 8'd9;
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_TILDE = 8'd126;

   // result kinds
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_TERM = 1'b1;

   // register indexes
   localparam logic CSR_BASE_ADDRESS = 1'b0;
   localparam logic CSR_BASE_OFFSET = 1'b1;

   // slots of one command, in emission order
   localparam logic [SLOT_W-1:0] SLOT_CHAR = SLOT_W'(HELD_DEPTH);
   localparam logic [SLOT_W-1:0] SLOT_TERM = SLOT_W'(MIN_RUN);

   typedef struct packed {
      logic [7:0]          data_byte;
      logic [OFFSET_W-1:0] byte_offset;
      logic                end_of_data;
   } req_type;

   typedef struct packed {
      logic              kind;
      logic [7:0]        char_value;
      logic [ADDR_W-1:0] string_address;
      logic              address_valid;
      logic              last;
   } rsp_type;

   // one command: the contiguous slots first_slot..last_slot are emitted
   typedef struct packed {
      logic [HELD_DEPTH-1:0][7:0] held;
      logic [7:0]                 char_value;
      logic [ADDR_W-1:0]          address;
      logic                       address_valid;
      logic [SLOT_W-1:0]          first_slot;
      logic [SLOT_W-1:0]          last_slot;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } push_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

   function automatic logic is_printable(input logic [7:0] b);
      return (b inside {[CHAR_SPACE:CHAR_TILDE]}) || (b == CHAR_TAB) || (b == CHAR_NEWLINE);
   endfunction

endpackage

@@ design/psx_front.sv @@
// front: accepts bytes, tracks the printable run and issues commands
module psx_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  psx_pkg::req_type                  req_payload,
   input  logic                              csr_write,
   input  logic                              csr_index,
   input  logic [psx_pkg::CSR_DATA_W-1:0]    csr_data,
   output psx_pkg::push_type                 push
);

   logic [psx_pkg::ADDR_W-1:0]   base_address_ff, base_address_in;
   logic [psx_pkg::OFFSET_W-1:0] base_offset_ff, base_offset_in;
   // base_address - base_offset, kept ready for the run start
   logic [psx_pkg::ADDR_W-1:0]   adj_ff, adj_in;

   logic [psx_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [7:0]                   held_ff [psx_pkg::HELD_DEPTH];
   logic [psx_pkg::ADDR_W-1:0]   start_ff, start_in;
   logic                         start_valid_ff, start_valid_in;

   logic                         accept;
   logic                         printable;
   logic                         count_zero, count_at_held, count_full;
   logic                         flush, emit, term;
   logic                         off_ge;
   logic [psx_pkg::ADDR_W-1:0]   new_addr;
   logic [psx_pkg::ADDR_W-1:0]   sub_a, sub_b;

   assign accept = req_valid && !req_stall;
   assign printable = psx_pkg::is_printable(req_payload.data_byte);

   assign count_zero = (count_ff == '0);
   assign count_at_held = (count_ff == psx_pkg::COUNT_W'(psx_pkg::HELD_DEPTH));
   assign count_full = (count_ff >= psx_pkg::COUNT_W'(psx_pkg::MIN_RUN));

   assign flush = printable && count_at_held;
   assign emit = printable && (count_at_held || count_full);
   assign term = (!printable && count_full) || (req_payload.end_of_data && emit);

   assign off_ge = (req_payload.byte_offset >= base_offset_ff);
   assign new_addr = off_ge ? (adj_ff + {{(psx_pkg::ADDR_W - psx_pkg::OFFSET_W){1'b0}},
                                         req_payload.byte_offset})
                            : '0;

   // configuration, with one shared subtractor for the adjusted base
   always_comb begin
      base_address_in = base_address_ff;
      base_offset_in = base_offset_ff;
      if (csr_index == psx_pkg::CSR_BASE_ADDRESS) begin
         sub_a = csr_data;
         sub_b = {{(psx_pkg::ADDR_W - psx_pkg::OFFSET_W){1'b0}}, base_offset_ff};
      end else begin
         sub_a = base_address_ff;
         sub_b = {{(psx_pkg::ADDR_W - psx_pkg::OFFSET_W){1'b0}},
                  csr_data[psx_pkg::OFFSET_W-1:0]};
      end
      adj_in = adj_ff;
      if (csr_write) begin
         adj_in = sub_a - sub_b;
         if (csr_index == psx_pkg::CSR_BASE_ADDRESS) begin
            base_address_in = csr_data;
         end else begin
            base_offset_in = csr_data[psx_pkg::OFFSET_W-1:0];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      start_in = start_ff;
      start_valid_in = start_valid_ff;
      if (accept) begin
         if (printable) begin
            if (count_zero) begin
               start_in = new_addr;
               start_valid_in = off_ge;
            end
            if (count_ff < psx_pkg::COUNT_W'(psx_pkg::HELD_DEPTH)) begin
               count_in = count_ff + psx_pkg::COUNT_W'(1);
            end else begin
               count_in = psx_pkg::COUNT_W'(psx_pkg::MIN_RUN);
            end
         end else begin
            count_in = '0;
         end
         if (req_payload.end_of_data) begin
            count_in = '0;
         end
      end
   end

   always_comb begin
      push.push = accept && (emit || term);
      for (int i = 0; i < psx_pkg::HELD_DEPTH; i++) begin
         push.cmd.held[i] = held_ff[i];
      end
      push.cmd.char_value = req_payload.data_byte;
      push.cmd.address = (printable && count_zero) ? new_addr : start_ff;
      push.cmd.address_valid = (printable && count_zero) ? off_ge : start_valid_ff;
      if (flush) begin
         push.cmd.first_slot = '0;
      end else if (emit) begin
         push.cmd.first_slot = psx_pkg::SLOT_CHAR;
      end else begin
         push.cmd.first_slot = psx_pkg::SLOT_TERM;
      end
      push.cmd.last_slot = term ? psx_pkg::SLOT_TERM : psx_pkg::SLOT_CHAR;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_address_ff <= '0;
         base_offset_ff <= '0;
         adj_ff <= '0;
         count_ff <= '0;
         start_ff <= '0;
         start_valid_ff <= 1'b0;
      end else begin
         base_address_ff <= base_address_in;
         base_offset_ff <= base_offset_in;
         adj_ff <= adj_in;
         count_ff <= count_in;
         start_ff <= start_in;
         start_valid_ff <= start_valid_in;
      end
   end

   // held bytes of the run's head
   always_ff @(posedge clock) begin
      for (int i = 0; i < psx_pkg::HELD_DEPTH; i++) begin
         if (accept && printable && (count_ff == psx_pkg::COUNT_W'(i))) begin
            held_ff[i] <= req_payload.data_byte;
         end
      end
   end

endmodule

@@ design/psx_queue.sv @@
// command queue between the front and the back
module psx_queue (
   input  logic               clock,
   input  logic               reset,
   input  psx_pkg::push_type  push,
   input  logic               pop,
   output logic               full,
   output psx_pkg::head_type  head
);

   psx_pkg::cmd_type             entry_ff [psx_pkg::QUEUE_DEPTH];
   logic [psx_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [psx_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [psx_pkg::QCNT_W-1:0]   count_ff, count_in;
   logic                         do_push, do_pop;

   assign full = (count_ff == psx_pkg::QCNT_W'(psx_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd = entry_ff[rd_ptr_ff];

   assign do_push = push.push && !full;
   assign do_pop = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + psx_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + psx_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + psx_pkg::QCNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - psx_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

@@ design/psx_back.sv @@
// back: walks each command's slots and drives the result register
module psx_back (
   input  logic               clock,
   input  logic               reset,
   input  psx_pkg::head_type  head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output psx_pkg::rsp_type   rsp_payload
);

   logic                         started_ff, started_in;
   logic [psx_pkg::SLOT_W-1:0]   idx_ff, idx_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   psx_pkg::rsp_type             rsp_ff, rsp_in;

   logic                         load, fire;
   logic [psx_pkg::SLOT_W-1:0]   slot;
   logic                         at_last;

   assign load = !rsp_valid_ff || !rsp_stall;
   assign fire = load && head.valid;
   assign slot = started_ff ? idx_ff : head.cmd.first_slot;
   assign at_last = (slot == head.cmd.last_slot);
   assign pop = fire && at_last;

   always_comb begin
      rsp_in.kind = (slot == psx_pkg::SLOT_TERM) ? psx_pkg::KIND_TERM : psx_pkg::KIND_CHAR;
      rsp_in.char_value = '0;
      for (int i = 0; i < psx_pkg::HELD_DEPTH; i++) begin
         if (slot == psx_pkg::SLOT_W'(i)) begin
            rsp_in.char_value = head.cmd.held[i];
         end
      end
      if (slot == psx_pkg::SLOT_CHAR) begin
         rsp_in.char_value = head.cmd.char_value;
      end
      rsp_in.string_address = head.cmd.address;
      rsp_in.address_valid = head.cmd.address_valid;
      rsp_in.last = at_last;
   end

   always_comb begin
      started_in = started_ff;
      idx_in = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (fire) begin
         rsp_valid_in = 1'b1;
         if (at_last) begin
            started_in = 1'b0;
         end else begin
            started_in = 1'b1;
            idx_in = slot + psx_pkg::SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         started_ff <= started_in;
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ design/printable_string_extractor.sv @@
// top level of the printable string extractor
//
//  channel  direction  handshake                 payload
//  req      in         req_valid / req_stall     psx_pkg::req_type (byte, offset, end mark)
//  rsp      out        rsp_valid / rsp_stall     psx_pkg::rsp_type (one string result)
//  csr      in         csr_write, csr_index      csr_data (base address / base offset)
//
//  one item is taken per cycle while the command queue has room
//  an item gives up to MIN_RUN + 1 results, sent one per cycle from the result register while rsp_stall is low
//  an item's results pass through the command queue, then the result register
//  the queue holds four commands; req_stall rises only when it is full
//  synchronous reset clears run state, base registers, queue and result valid flag; no clearing pass
module printable_string_extractor (
   input  logic                            clock,
   input  logic                            reset,
   // byte items
   input  logic                            req_valid,
   output logic                            req_stall,
   input  psx_pkg::req_type                req_payload,
   // string results
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output psx_pkg::rsp_type                rsp_payload,
   // configuration writes
   input  logic                            csr_write,
   input  logic                            csr_index,
   input  logic [psx_pkg::CSR_DATA_W-1:0]  csr_data
);

   psx_pkg::push_type  push;
   psx_pkg::head_type  head;
   logic               queue_full;
   logic               pop;

   // queue backpressure goes straight to the byte source
   assign req_stall = queue_full;

   // classifier and run tracker
   psx_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (queue_full),
      .req_payload (req_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .push        (push)
   );

   // decouples byte intake from result bursts
   psx_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   // expands commands into result items
   psx_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // a terminator always closes the results of its item
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.kind == psx_pkg::KIND_TERM)) |-> rsp_payload.last)
      else $error("terminator without last");

   // an invalid start carries a zero address
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.address_valid) |-> (rsp_payload.string_address == '0))
      else $error("invalid start with nonzero address");

   // terminators carry no character
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.kind == psx_pkg::KIND_TERM)) |-> (rsp_payload.char_value == '0))
      else $error("terminator with character");

   // queue is empty and open right after reset
   assert property (@(posedge clock) reset |=> !req_stall)
      else $error("stall after reset");

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench of the printable string extractor
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // a directed row: the byte item, and where the outcome is obvious, the number of
   // results it must give and the run address they carry (n_typed < 0: predictor only)
   typedef struct packed {
      logic [7:0]                 data;
      logic [31:0]                offset;
      logic                       eod;
      byte                        n_typed;
      logic [psx_pkg::ADDR_W-1:0] addr_typed;
      logic                       ok_typed;
   } dir_row_type;

   localparam int DIR_ROWS = 24;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS = 56;
   localparam int DRAIN_LIMIT = 20000;
   // command queue plus result register, with margin, for items that leave no result
   localparam int SETTLE_CYCLES = 12;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_stall;
   psx_pkg::req_type  req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   psx_pkg::rsp_type  rsp_payload;
   logic              csr_write = 1'b0;
   logic              csr_index = psx_pkg::CSR_BASE_ADDRESS;
   logic [psx_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // run-scan state of the predictor, kept apart from the block
   int unsigned       run_len = 0;
   logic [7:0]        held_text [psx_pkg::MIN_RUN-1];
   logic [psx_pkg::ADDR_W-1:0]   run_addr = '0;
   logic                         run_addr_ok = 1'b0;
   logic [psx_pkg::ADDR_W-1:0]   cfg_base_address = '0;
   logic [psx_pkg::OFFSET_W-1:0] cfg_base_offset = '0;

   // results still owed by the block, oldest first
   psx_pkg::rsp_type string_results_due [$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int items_sent = 0;
   int results_seen = 0;
   int strings_closed = 0;
   int settings_used = 0;
   int error_count = 0;

   // no gaps, sender gaps, receiver stalls, both
   int send_gap_pct [4] = '{0, 48, 0, 18};
   int recv_gap_pct [4] = '{0, 0, 48, 18};

   // directed part, run with base address 0x1000 and base offset 0x100
   dir_row_type script [DIR_ROWS] = '{
      '{8'h00, 32'h0000_0100, 1'b0,  0, 48'h0, 1'b0},       // nothing open, nothing out
      '{8'h41, 32'h0000_0100, 1'b0,  0, 48'h0, 1'b0},       // run opens at the base
      '{8'h62, 32'h0000_0101, 1'b0,  0, 48'h0, 1'b0},
      '{8'h20, 32'h0000_0102, 1'b0,  0, 48'h0, 1'b0},       // space, lowest of the range
      '{8'h7e, 32'h0000_0103, 1'b0,  4, 48'h1000, 1'b1},    // tilde completes the minimum
      '{8'h09, 32'h0000_0104, 1'b0,  1, 48'h1000, 1'b1},    // tab goes straight out
      '{8'h0a, 32'h0000_0105, 1'b0,  1, 48'h1000, 1'b1},    // newline too
      '{8'h7f, 32'h0000_0106, 1'b0,  1, 48'h1000, 1'b1},    // delete closes the string
      '{8'h80, 32'h0000_0107, 1'b0,  0, 48'h0, 1'b0},       // top-bit bytes are not text
      '{8'h78, 32'h0000_0108, 1'b0,  0, 48'h0, 1'b0},
      '{8'h79, 32'h0000_0109, 1'b0,  0, 48'h0, 1'b0},
      '{8'hff, 32'h0000_010a, 1'b0,  0, 48'h0, 1'b0},       // short run dropped silently
      '{8'h1f, 32'h0000_010b, 1'b0,  0, 48'h0, 1'b0},
      '{8'h61, 32'h0000_00ff, 1'b0,  0, 48'h0, 1'b0},       // run opens below the base
      '{8'h62, 32'h0000_0100, 1'b0,  0, 48'h0, 1'b0},
      '{8'h63, 32'h0000_0101, 1'b0,  0, 48'h0, 1'b0},
      '{8'h64, 32'h0000_0102, 1'b1,  5, 48'h0, 1'b0},       // end mark on text: chars then close
      '{8'h65, 32'hffff_ffff, 1'b0,  0, 48'h0, 1'b0},       // fresh scan at the top offset
      '{8'h66, 32'h0000_0000, 1'b0,  0, 48'h0, 1'b0},       // offset jump inside a run
      '{8'h67, 32'h0000_0001, 1'b0,  0, 48'h0, 1'b0},
      '{8'h68, 32'h0000_0002, 1'b0, -1, 48'h0, 1'b0},
      '{8'h00, 32'h0000_0003, 1'b1, -1, 48'h0, 1'b0},       // end mark on a break: one close only
      '{8'h7a, 32'h0000_0004, 1'b1,  0, 48'h0, 1'b0},       // lone byte ended by the mark
      '{8'h0b, 32'h0000_0005, 1'b1,  0, 48'h0, 1'b0}        // vertical tab is not text
   };

   printable_string_extractor uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // only the first ten mismatches are printed, the rest are just counted
   task automatic flag_error(input string what);
      error_count++;
      if (error_count <= 10) begin
         $display("mismatch: %s", what);
      end
   endtask

   // text bytes: space to tilde, plus tab and newline
   function automatic logic is_text_byte(input logic [7:0] b);
      return (b >= psx_pkg::CHAR_SPACE && b <= psx_pkg::CHAR_TILDE) ||
             b == psx_pkg::CHAR_TAB || b == psx_pkg::CHAR_NEWLINE;
   endfunction

   function automatic psx_pkg::rsp_type string_result(input logic kind, input logic [7:0] ch);
      psx_pkg::rsp_type r;
      r.kind = kind;
      r.char_value = ch;
      r.string_address = run_addr;
      r.address_valid = run_addr_ok;
      r.last = 1'b0;
      return r;
   endfunction

   // predictor: advance the run scan by one byte item and queue the results it owes
   task automatic extract_strings(input psx_pkg::req_type item, output int produced);
      psx_pkg::rsp_type batch [psx_pkg::MIN_RUN+1];
      int n;
      n = 0;
      if (is_text_byte(item.data_byte)) begin
         // the run address is fixed by the first byte, using the settings of that moment
         if (run_len == 0) begin
            if (item.byte_offset >= cfg_base_offset) begin
               run_addr_ok = 1'b1;
               run_addr = cfg_base_address +
                          psx_pkg::ADDR_W'(item.byte_offset - cfg_base_offset);
            end else begin
               run_addr_ok = 1'b0;
               run_addr = '0;
            end
         end
         if (run_len < psx_pkg::MIN_RUN - 1) begin
            held_text[run_len] = item.data_byte;
            run_len++;
         end else if (run_len == psx_pkg::MIN_RUN - 1) begin
            // minimum reached: release the held bytes, then this one
            for (int i = 0; i < psx_pkg::MIN_RUN - 1; i++) begin
               batch[n] = string_result(psx_pkg::KIND_CHAR, held_text[i]);
               n++;
            end
            batch[n] = string_result(psx_pkg::KIND_CHAR, item.data_byte);
            n++;
            run_len = psx_pkg::MIN_RUN;
         end else begin
            batch[n] = string_result(psx_pkg::KIND_CHAR, item.data_byte);
            n++;
         end
      end else begin
         if (run_len >= psx_pkg::MIN_RUN) begin
            batch[n] = string_result(psx_pkg::KIND_TERM, 8'h00);
            n++;
         end
         run_len = 0;
      end
      // the end mark closes whatever is still open after the byte itself
      if (item.end_of_data) begin
         if (run_len >= psx_pkg::MIN_RUN) begin
            batch[n] = string_result(psx_pkg::KIND_TERM, 8'h00);
            n++;
         end
         run_len = 0;
      end
      if (n > 0) begin
         batch[n-1].last = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
         string_results_due.push_back(batch[i]);
      end
      produced = n;
   endtask

   // hand one byte item over; the prediction is made once acceptance is certain
   task automatic send_item(input psx_pkg::req_type item, output int produced);
      logic taken;
      produced = 0;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      taken = 1'b0;
      while (!taken) begin
         // stall is settled by the falling edge and holds to the next rising one
         @(negedge clock);
         if (!req_stall) begin
            taken = 1'b1;
            extract_strings(item, produced);
         end
         @(posedge clock);
      end
      items_sent++;
   endtask

   // wait until every owed result has come, then let the block go quiet
   task automatic settle();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      while (string_results_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (string_results_due.size() != 0) begin
         flag_error($sformatf("%0d results never arrived", string_results_due.size()));
         string_results_due.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [psx_pkg::CSR_DATA_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      if (idx == psx_pkg::CSR_BASE_ADDRESS) begin
         cfg_base_address = value;
      end else begin
         cfg_base_offset = value[psx_pkg::OFFSET_W-1:0];
      end
      @(posedge clock);
   endtask

   // both registers, only while the block is idle; the offset write carries junk up top
   task automatic apply_settings(input logic [psx_pkg::ADDR_W-1:0] addr,
                                 input logic [psx_pkg::OFFSET_W-1:0] off);
      settle();
      write_reg(psx_pkg::CSR_BASE_ADDRESS, addr);
      write_reg(psx_pkg::CSR_BASE_OFFSET, {16'($urandom), off});
      csr_write <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [7:0] pick_text_byte();
      case ($urandom_range(0, 19))
         0: begin
            return psx_pkg::CHAR_TAB;
         end
         1: begin
            return psx_pkg::CHAR_NEWLINE;
         end
         default: begin
            return 8'($urandom_range(32, 126));
         end
      endcase
   endfunction

   function automatic logic [7:0] pick_break_byte();
      case ($urandom_range(0, 2))
         0: begin
            return 8'($urandom_range(0, 8));
         end
         1: begin
            return 8'($urandom_range(11, 31));
         end
         default: begin
            return 8'($urandom_range(127, 255));
         end
      endcase
   endfunction

   // mostly whole strings of random text and length with a break after them, some noise,
   // offsets that walk across the base and now and then jump anywhere
   task automatic run_random_phase(input int count);
      psx_pkg::req_type item;
      logic [psx_pkg::OFFSET_W-1:0] pos;
      int sent;
      int len;
      int produced;
      sent = 0;
      item = '0;
      pos = cfg_base_offset - psx_pkg::OFFSET_W'($urandom_range(0, 6));
      while (sent < count) begin
         if ($urandom_range(0, 9) < 8) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 12);
            for (int k = 0; k < len; k++) begin
               item.data_byte = pick_text_byte();
               item.byte_offset = pos;
               item.end_of_data = (k == len - 1) && ($urandom_range(0, 7) == 0);
               send_item(item, produced);
               pos++;
               sent++;
            end
            // a missing break lets the next string run on into a longer one
            if (!item.end_of_data && $urandom_range(0, 4) != 0) begin
               item.data_byte = pick_break_byte();
               item.byte_offset = pos;
               item.end_of_data = ($urandom_range(0, 9) == 0);
               send_item(item, produced);
               pos++;
               sent++;
            end
         end else begin
            item.data_byte = 8'($urandom);
            item.byte_offset = ($urandom_range(0, 1) == 0) ?
                               psx_pkg::OFFSET_W'($urandom) : pos;
            item.end_of_data = ($urandom_range(0, 5) == 0);
            send_item(item, produced);
            pos++;
            sent++;
         end
         if (item.end_of_data) begin
            pos = cfg_base_offset - psx_pkg::OFFSET_W'($urandom_range(0, 3));
         end else if ($urandom_range(0, 19) == 0) begin
            pos = psx_pkg::OFFSET_W'($urandom);
         end
      end
   endtask

   // receiver: stall drawn afresh every cycle at the phase's rate
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < recv_stall_pct);
   end

   // checker: a result is taken at the next rising edge when valid and not stalled
   always @(negedge clock) begin : result_check
      psx_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (rsp_payload.kind == psx_pkg::KIND_TERM) begin
            strings_closed++;
         end
         if (string_results_due.size() == 0) begin
            flag_error($sformatf("unexpected result kind %0b char %02h addr %012h ok %0b last %0b",
               rsp_payload.kind, rsp_payload.char_value, rsp_payload.string_address,
               rsp_payload.address_valid, rsp_payload.last));
         end else begin
            want = string_results_due.pop_front();
            if (rsp_payload.kind !== want.kind || rsp_payload.char_value !== want.char_value ||
                rsp_payload.string_address !== want.string_address ||
                rsp_payload.address_valid !== want.address_valid ||
                rsp_payload.last !== want.last) begin
               flag_error($sformatf({"result %0d: expected kind %0b char %02h addr %012h ok %0b",
                  " last %0b, got kind %0b char %02h addr %012h ok %0b last %0b"},
                  results_seen, want.kind, want.char_value, want.string_address,
                  want.address_valid, want.last, rsp_payload.kind, rsp_payload.char_value,
                  rsp_payload.string_address, rsp_payload.address_valid, rsp_payload.last));
            end
         end
      end
   end

   // main sequence: reset, directed table, then random phases over several settings
   initial begin : stimulus
      logic [psx_pkg::ADDR_W-1:0] phase_addr [RANDOM_PHASES];
      logic [psx_pkg::OFFSET_W-1:0] phase_off [RANDOM_PHASES];
      psx_pkg::req_type item;
      int produced;

      // extremes first, then random settings, one of them with a small base offset
      phase_addr = '{48'h0, 48'hffff_ffff_ffff, 48'h0, 48'hffff_ffff_ffff,
                     {16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)},
                     {16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)}};
      phase_off = '{32'h0, 32'h0, 32'hffff_ffff, 32'hffff_ffff,
                    32'($urandom), 32'($urandom_range(0, 255)), 32'($urandom),
                    32'hffff_ff00 + 32'($urandom_range(0, 255))};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part without any idling
      apply_settings(48'h1000, 32'h100);
      for (int i = 0; i < DIR_ROWS; i++) begin
         item.data_byte = script[i].data;
         item.byte_offset = script[i].offset;
         item.end_of_data = script[i].eod;
         send_item(item, produced);
         if (script[i].n_typed >= 0 && (produced != script[i].n_typed ||
             (produced > 0 && (run_addr !== script[i].addr_typed ||
                               run_addr_ok !== script[i].ok_typed)))) begin
            flag_error($sformatf("directed row %0d: predicted %0d results at %012h ok %0b",
               i, produced, run_addr, run_addr_ok));
         end
      end

      // random part: each phase new settings and the next idling pattern
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         apply_settings(phase_addr[p], phase_off[p]);
         send_idle_pct = send_gap_pct[p % 4];
         recv_stall_pct = recv_gap_pct[p % 4];
         run_random_phase(PHASE_ITEMS);
      end

      // let stragglers show up as unexpected results
      settle();
      repeat (20) @(posedge clock);

      $display("run covered %0d byte items under %0d register settings, %0d results checked",
         items_sent, settings_used, results_seen);
      $display("%0d strings closed, %0d mismatches", strings_closed, error_count);
      if (error_count == 0) begin
         $display("PASS printable_string_extractor");
      end else begin
         $display("FAIL printable_string_extractor");
      end
      $finish;
   end

   // backstop in case the block hangs
   initial begin
      #5ms;
      $display("FAIL printable_string_extractor");
      $finish;
   end

endmodule
